// File: rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the densest slab selector.
// ----------------------------------------------------------------------------
package dss_pkg;

    // fixed field widths
    localparam int FIELD_BITS     = 16;
    localparam int INDEX_BITS     = 6;
    localparam int PLANE_BITS     = 5;
    localparam int SLAB_BITS      = 6;
    localparam int THRESH_BITS    = 7;
    localparam int CFG_INDEX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_X   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Y   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Z   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLAB_COUNT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESH_DIV = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PROJ,
        ST_SETUP,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT,
        ST_EDRAIN
    } state_t;

    // status of the plane test pipeline
    typedef struct packed {
        logic active;
        logic hit;
    } near_status_t;

endpackage
`default_nettype wire

// File: rtl/dss_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/dss_near.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_near
// Pipelined plane test: |slab*(p-min) - target| * thresh < span, one point
// per cycle, with the point index and coordinates carried alongside.
// ----------------------------------------------------------------------------
module dss_near #(
    parameter int PW   = 34,
    parameter int PTW  = 48,
    parameter int AW   = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic [AW-1:0]                         in_idx,
    input  wire logic signed [PW-1:0]                  in_proj,
    input  wire logic [PTW-1:0]                        in_pt,
    input  wire logic signed [PW-1:0]                  min_proj,
    input  wire logic [PW-1:0]                         span,
    input  wire logic [PW+4:0]                         target,
    input  wire logic [dss_pkg::SLAB_BITS-1:0]         slab,
    input  wire logic [dss_pkg::THRESH_BITS-1:0]       thresh,
    output dss_pkg::near_status_t                      status,
    output logic [AW-1:0]                              out_idx,
    output logic [PTW-1:0]                             out_pt
);

    localparam int QW = PW + dss_pkg::SLAB_BITS;
    localparam int DW = QW + 1;
    localparam int RW = QW + dss_pkg::THRESH_BITS;

    logic            iss_v_reg, a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic [AW-1:0]   iss_idx_reg, a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg;
    logic [PTW-1:0]  a_pt_reg, b_pt_reg, c_pt_reg, d_pt_reg;
    logic [PW-1:0]   a_diff_reg;
    logic [QW-1:0]   b_q_reg;
    logic [QW-1:0]   c_abs_reg;
    logic [RW-1:0]   d_prod_reg;
    logic signed [DW-1:0] delta;

    // signed distance to the plane
    assign delta = $signed({1'b0, b_q_reg}) - $signed({2'b00, target});

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v_reg <= 1'b0;
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
        end
        else
        begin
            iss_v_reg <= in_valid;
            a_v_reg   <= iss_v_reg;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        iss_idx_reg <= in_idx;
        a_idx_reg   <= iss_idx_reg;
        a_pt_reg    <= in_pt;
        a_diff_reg  <= PW'(in_proj - min_proj);
        b_idx_reg   <= a_idx_reg;
        b_pt_reg    <= a_pt_reg;
        b_q_reg     <= QW'(a_diff_reg) * QW'(slab);
        c_idx_reg   <= b_idx_reg;
        c_pt_reg    <= b_pt_reg;
        c_abs_reg   <= delta[DW-1] ? QW'(-delta) : QW'(delta);
        d_idx_reg   <= c_idx_reg;
        d_pt_reg    <= c_pt_reg;
        d_prod_reg  <= RW'(c_abs_reg) * RW'(thresh);
    end

    assign status.active = iss_v_reg | a_v_reg | b_v_reg | c_v_reg | d_v_reg;
    assign status.hit    = d_v_reg && (d_prod_reg < RW'(span));
    assign out_idx       = d_idx_reg;
    assign out_pt        = d_pt_reg;

endmodule
`default_nettype wire

// File: rtl/densest_slab_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// densest_slab_select
// Loads a point set, finds the densest plane along a normal, emits its points.
// ----------------------------------------------------------------------------
// Usage:
//   Points are loaded with start while busy is low, one per cycle. Up to
//   MAX_POINTS are kept; later ones are dropped and reported as overflowed.
//   A point with last_point high closes the set and raises busy.
//   Compute: a projection pass per point (one shared multiplier over x, y
//   and z), a setup step, then for each of the slab_count-1 planes
//   (slab_count clamped to 2..32) a scan pass over all points plus a
//   pipeline drain, and a final emit pass over all points with its drain.
//   Results appear on the output ports with result_valid high for exactly
//   one cycle each, in load order; last_result marks the final one. When no
//   point qualifies, one result with none_found high is given. The receiver
//   cannot stall the block. busy falls in the cycle of the final result when
//   none is found, otherwise after it, once the pipeline has drained.
//   Registers are written through wr_en, wr_index and wr_data while idle;
//   the user must keep to this, the block itself does not enforce it.
//   Reset restores the register defaults and empties the point set.
// ----------------------------------------------------------------------------
module densest_slab_select #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [dss_pkg::FIELD_BITS-1:0]  point_x,
    input  wire logic signed [dss_pkg::FIELD_BITS-1:0]  point_y,
    input  wire logic signed [dss_pkg::FIELD_BITS-1:0]  point_z,
    input  wire logic                                   last_point,
    input  wire logic                                   wr_en,
    input  wire logic [dss_pkg::CFG_INDEX_BITS-1:0]     wr_index,
    input  wire logic [dss_pkg::FIELD_BITS-1:0]         wr_data,
    output logic                                        result_valid,
    output logic signed [dss_pkg::FIELD_BITS-1:0]       out_x,
    output logic signed [dss_pkg::FIELD_BITS-1:0]       out_y,
    output logic signed [dss_pkg::FIELD_BITS-1:0]       out_z,
    output logic [dss_pkg::INDEX_BITS-1:0]              out_index,
    output logic [dss_pkg::PLANE_BITS-1:0]              winning_plane,
    output logic                                        none_found,
    output logic                                        overflowed,
    output logic                                        last_result
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int PW   = CW + 18;
    localparam int TW   = PW + 5;
    localparam int PTW  = 3 * CW;
    localparam int MW   = CW + dss_pkg::FIELD_BITS;
    localparam int FB   = dss_pkg::FIELD_BITS;
    localparam int PB   = dss_pkg::PLANE_BITS;

    // configuration registers
    logic signed [FB-1:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [dss_pkg::SLAB_BITS-1:0]   slab_count_reg;
    logic [dss_pkg::THRESH_BITS-1:0] thresh_div_reg;

    // control and datapath registers
    dss_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [2:0]      ph_reg, ph_next;
    logic signed [MW-1:0] mul_reg, mul_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] min_reg, min_next, max_reg, max_next;
    logic [PW-1:0]   span_reg, span_next;
    logic [TW-1:0]   target_reg, target_next;
    logic [PB-1:0]   plane_reg, plane_next, best_reg, best_next;
    logic [CNTW-1:0] best_cnt_reg, best_cnt_next;
    logic [TW-1:0]   best_tgt_reg, best_tgt_next;
    logic [CNTW-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CNTW-1:0] emit_cnt_reg, emit_cnt_next;

    // output registers
    logic          rv_reg, rv_next;
    logic [FB-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [dss_pkg::INDEX_BITS-1:0] oi_reg, oi_next;
    logic [PB-1:0] op_reg, op_next;
    logic          on_reg, on_next, oo_reg, oo_next, ol_reg, ol_next;

    // memory ports
    logic            pt_we, pt_re, pj_we, pj_re;
    logic [AW-1:0]   pt_waddr, rd_addr;
    logic [PTW-1:0]  pt_wdata, pt_rdata;
    logic signed [PW-1:0] pj_wdata, pj_rdata;

    // helpers
    logic [dss_pkg::SLAB_BITS-1:0]   s_eff;
    logic [dss_pkg::THRESH_BITS-1:0] t_eff;
    logic [PB-1:0]   plane_last;
    logic            accept, last_issue, upd;
    logic signed [CW-1:0] rx, ry, rz, mcoord;
    logic signed [FB-1:0] mnorm;
    logic signed [PW-1:0] proj_sum;
    logic [PB-1:0]   nb;
    logic [CNTW-1:0] nbc;
    logic [TW-1:0]   nbt;
    logic            eval_issue;
    dss_pkg::near_status_t ns;
    logic [AW-1:0]   n_idx;
    logic [PTW-1:0]  n_pt;
    logic signed [CW-1:0] nx_c, ny_c, nz_c;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg   <= '0;
            normal_y_reg   <= '0;
            normal_z_reg   <= 16'sd16384;
            slab_count_reg <= 6'd8;
            thresh_div_reg <= 7'd2;
        end
        else if (wr_en)
        begin
            case (wr_index)
                dss_pkg::REG_NORMAL_X:   normal_x_reg   <= wr_data;
                dss_pkg::REG_NORMAL_Y:   normal_y_reg   <= wr_data;
                dss_pkg::REG_NORMAL_Z:   normal_z_reg   <= wr_data;
                dss_pkg::REG_SLAB_COUNT: slab_count_reg <= wr_data[dss_pkg::SLAB_BITS-1:0];
                dss_pkg::REG_THRESH_DIV: thresh_div_reg <= wr_data[dss_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped slab count and threshold divider
    always_comb
    begin
        if (slab_count_reg < 6'd2)
            s_eff = 6'd2;
        else if (slab_count_reg > 6'd32)
            s_eff = 6'd32;
        else
            s_eff = slab_count_reg;
        if (thresh_div_reg == 7'd0)
            t_eff = 7'd1;
        else if (thresh_div_reg > 7'd64)
            t_eff = 7'd64;
        else
            t_eff = thresh_div_reg;
    end

    assign plane_last = PB'(s_eff - 6'd2);

    // point store and projection store
    dss_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (rd_addr),
        .rdata (pt_rdata)
    );

    dss_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pj_ram (
        .clk   (clk),
        .we    (pj_we),
        .waddr (j_reg),
        .wdata (pj_wdata),
        .re    (pj_re),
        .raddr (rd_addr),
        .rdata (pj_rdata)
    );

    // plane test pipeline
    dss_near #(.PW(PW), .PTW(PTW), .AW(AW)) u_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (eval_issue),
        .in_idx   (j_reg),
        .in_proj  (pj_rdata),
        .in_pt    (pt_rdata),
        .min_proj (min_reg),
        .span     (span_reg),
        .target   (target_reg),
        .slab     (s_eff),
        .thresh   (t_eff),
        .status   (ns),
        .out_idx  (n_idx),
        .out_pt   (n_pt)
    );

    // stored coordinates and shared projection multiplier inputs
    assign rx = pt_rdata[3*CW-1:2*CW];
    assign ry = pt_rdata[2*CW-1:CW];
    assign rz = pt_rdata[CW-1:0];
    assign nx_c = n_pt[3*CW-1:2*CW];
    assign ny_c = n_pt[2*CW-1:CW];
    assign nz_c = n_pt[CW-1:0];

    always_comb
    begin
        case (ph_reg)
            3'd1:    begin mcoord = rx; mnorm = normal_x_reg; end
            3'd2:    begin mcoord = ry; mnorm = normal_y_reg; end
            default: begin mcoord = rz; mnorm = normal_z_reg; end
        endcase
    end

    assign proj_sum   = acc_reg + PW'(mul_reg);
    assign accept     = start && (state_reg == dss_pkg::ST_LOAD);
    assign last_issue = (CNTW'(j_reg) + CNTW'(1)) == cnt_reg;
    assign upd        = hit_cnt_reg > best_cnt_reg;
    assign nb         = upd ? plane_reg : best_reg;
    assign nbc        = upd ? hit_cnt_reg : best_cnt_reg;
    assign nbt        = upd ? target_reg : best_tgt_reg;

    // sequencer next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        j_next        = j_reg;
        ph_next       = ph_reg;
        mul_next      = mul_reg;
        acc_next      = acc_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        span_next     = span_reg;
        target_next   = target_reg;
        plane_next    = plane_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        best_tgt_next = best_tgt_reg;
        hit_cnt_next  = hit_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        rv_next       = 1'b0;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        oi_next       = oi_reg;
        op_next       = op_reg;
        on_next       = on_reg;
        oo_next       = oo_reg;
        ol_next       = ol_reg;
        pt_we         = 1'b0;
        pt_waddr      = AW'(cnt_reg);
        pt_wdata      = {CW'($unsigned(point_x)), CW'($unsigned(point_y)),
                         CW'($unsigned(point_z))};
        pt_re         = 1'b0;
        pj_we         = 1'b0;
        pj_re         = 1'b0;
        pj_wdata      = proj_sum;
        rd_addr       = j_reg;
        eval_issue    = 1'b0;

        // pipeline results: count hits or deliver a result transfer
        if (ns.hit)
        begin
            if (state_reg == dss_pkg::ST_EMIT || state_reg == dss_pkg::ST_EDRAIN)
            begin
                rv_next       = 1'b1;
                ox_next       = FB'(nx_c);
                oy_next       = FB'(ny_c);
                oz_next       = FB'(nz_c);
                oi_next       = dss_pkg::INDEX_BITS'(n_idx);
                op_next       = best_reg;
                on_next       = 1'b0;
                oo_next       = ovf_reg;
                ol_next       = (emit_cnt_reg + CNTW'(1)) == best_cnt_reg;
                emit_cnt_next = emit_cnt_reg + CNTW'(1);
            end
            else
            begin
                hit_cnt_next = hit_cnt_reg + CNTW'(1);
            end
        end

        case (state_reg)
            // load points
            dss_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (cnt_reg < CNTW'(MAX_POINTS))
                    begin
                        pt_we    = 1'b1;
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_point)
                    begin
                        state_next = dss_pkg::ST_PROJ;
                        j_next     = '0;
                        ph_next    = 3'd0;
                    end
                end
            end

            // projection pass: read, three products in turn, write; one point at a time
            dss_pkg::ST_PROJ:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd0: pt_re = 1'b1;
                    3'd1: mul_next = $signed(MW'(mcoord)) * $signed(MW'(mnorm));
                    3'd2:
                    begin
                        acc_next = PW'(mul_reg);
                        mul_next = $signed(MW'(mcoord)) * $signed(MW'(mnorm));
                    end
                    3'd3:
                    begin
                        acc_next = proj_sum;
                        mul_next = $signed(MW'(mcoord)) * $signed(MW'(mnorm));
                    end
                    default:
                    begin
                        pj_we   = 1'b1;
                        ph_next = 3'd0;
                        if (j_reg == '0 || proj_sum < min_reg)
                            min_next = proj_sum;
                        if (j_reg == '0 || proj_sum > max_reg)
                            max_next = proj_sum;
                        if (last_issue)
                            state_next = dss_pkg::ST_SETUP;
                        else
                            j_next = j_reg + AW'(1);
                    end
                endcase
            end

            // span and first plane
            dss_pkg::ST_SETUP:
            begin
                span_next     = PW'(max_reg - min_reg);
                target_next   = TW'(PW'(max_reg - min_reg));
                best_tgt_next = TW'(PW'(max_reg - min_reg));
                best_next     = '0;
                best_cnt_next = '0;
                plane_next    = '0;
                hit_cnt_next  = '0;
                j_next        = '0;
                state_next    = dss_pkg::ST_SCAN;
            end

            // issue all points against the current plane
            dss_pkg::ST_SCAN, dss_pkg::ST_EMIT:
            begin
                pt_re      = 1'b1;
                pj_re      = 1'b1;
                eval_issue = 1'b1;
                if (last_issue)
                    state_next = (state_reg == dss_pkg::ST_SCAN) ?
                                 dss_pkg::ST_WAIT : dss_pkg::ST_EDRAIN;
                else
                    j_next = j_reg + AW'(1);
            end

            // close a plane once the pipeline is empty, then scan on, emit or report none
            dss_pkg::ST_WAIT:
            begin
                if (!ns.active)
                begin
                    best_next     = nb;
                    best_cnt_next = nbc;
                    best_tgt_next = nbt;
                    hit_cnt_next  = '0;
                    j_next        = '0;
                    if (plane_reg == plane_last)
                    begin
                        if (nbc == '0)
                        begin
                            rv_next    = 1'b1;
                            ox_next    = '0;
                            oy_next    = '0;
                            oz_next    = '0;
                            oi_next    = '0;
                            op_next    = nb;
                            on_next    = 1'b1;
                            oo_next    = ovf_reg;
                            ol_next    = 1'b1;
                            cnt_next   = '0;
                            ovf_next   = 1'b0;
                            min_next   = '0;
                            max_next   = '0;
                            state_next = dss_pkg::ST_LOAD;
                        end
                        else
                        begin
                            target_next   = nbt;
                            emit_cnt_next = '0;
                            state_next    = dss_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        plane_next  = plane_reg + PB'(1);
                        target_next = target_reg + TW'(span_reg);
                        state_next  = dss_pkg::ST_SCAN;
                    end
                end
            end

            // finish the emit pass and start a new set
            dss_pkg::ST_EDRAIN:
            begin
                if (!ns.active)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    min_next   = '0;
                    max_next   = '0;
                    state_next = dss_pkg::ST_LOAD;
                end
            end

            default: state_next = dss_pkg::ST_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dss_pkg::ST_LOAD;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            j_reg        <= '0;
            ph_reg       <= 3'd0;
            min_reg      <= '0;
            max_reg      <= '0;
            plane_reg    <= '0;
            best_reg     <= '0;
            best_cnt_reg <= '0;
            hit_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            j_reg        <= j_next;
            ph_reg       <= ph_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            plane_reg    <= plane_next;
            best_reg     <= best_next;
            best_cnt_reg <= best_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            rv_reg       <= rv_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        mul_reg      <= mul_next;
        acc_reg      <= acc_next;
        span_reg     <= span_next;
        target_reg   <= target_next;
        best_tgt_reg <= best_tgt_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oz_reg       <= oz_next;
        oi_reg       <= oi_next;
        op_reg       <= op_next;
        on_reg       <= on_next;
        oo_reg       <= oo_next;
        ol_reg       <= ol_next;
    end

    assign busy          = state_reg != dss_pkg::ST_LOAD;
    assign result_valid  = rv_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_z         = oz_reg;
    assign out_index     = oi_reg;
    assign winning_plane = op_reg;
    assign none_found    = on_reg;
    assign overflowed    = oo_reg;
    assign last_result   = ol_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("result after the final result");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dss_pkg::ST_EMIT || state_reg == dss_pkg::ST_EDRAIN)
        |-> emit_cnt_reg <= best_cnt_reg)
        else $error("more results than counted hits");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> winning_plane <= plane_last)
        else $error("winning plane out of range");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the densest slab selector: point sets are loaded
// with random gaps, a local predictor picks the densest plane, and every
// emitted point is compared in order against the predicted list.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY   = 64;
    localparam int WATCHDOG   = 200000;
    localparam int DRAIN_WAIT = 40;

    // one emitted point
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [5:0]         idx;
        logic [4:0]         plane;
        logic               none;
        logic               ovf;
        logic               last;
    } slab_pick_t;

    // one directed stimulus row
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
        logic               fixed;
        logic               none;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] point_x = '0;
    logic signed [15:0] point_y = '0;
    logic signed [15:0] point_z = '0;
    logic last_point = 1'b0;
    logic wr_en = 1'b0;
    logic [dss_pkg::CFG_INDEX_BITS-1:0] wr_index = '0;
    logic [15:0] wr_data = '0;
    logic result_valid;
    logic signed [15:0] out_x, out_y, out_z;
    logic [5:0] out_index;
    logic [4:0] winning_plane;
    logic none_found, overflowed, last_result;

    // predictor state
    logic signed [15:0] set_pts [CAPACITY][3];
    int                 set_len;
    logic               set_ovf;
    logic signed [15:0] nx = 16'sd0, ny = 16'sd0, nz = 16'sd16384;
    logic [5:0]         slabs = 6'd8;
    logic [6:0]         tdiv = 7'd2;

    slab_pick_t picks_due[$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;

    always #4 clk = ~clk;

    densest_slab_select u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .last_point(last_point), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .result_valid(result_valid), .out_x(out_x),
        .out_y(out_y), .out_z(out_z), .out_index(out_index),
        .winning_plane(winning_plane), .none_found(none_found),
        .overflowed(overflowed), .last_result(last_result)
    );

    function automatic longint slab_proj(int j);
        return longint'(nx) * set_pts[j][0] + longint'(ny) * set_pts[j][1]
             + longint'(nz) * set_pts[j][2];
    endfunction

    function automatic bit in_slab(longint p, longint lo, longint s, longint t,
                                   longint pl, longint span);
        longint d;
        d = s * (p - lo) - (pl + 1) * span;
        if (d < 0) d = -d;
        return d * t < span;
    endfunction

    // close the set: choose the densest plane and queue its points
    task automatic close_set();
        longint s, t, lo, hi, span, p;
        int best, best_n, c, first_k;
        slab_pick_t r;
        s = (slabs < 2) ? 2 : (slabs > 32) ? 32 : slabs;
        t = (tdiv < 1) ? 1 : (tdiv > 64) ? 64 : tdiv;
        lo = 0; hi = 0; best = 0; best_n = 0;
        for (int j = 0; j < set_len; j++)
        begin
            p = slab_proj(j);
            if (j == 0 || p < lo) lo = p;
            if (j == 0 || p > hi) hi = p;
        end
        span = hi - lo;
        for (int i = 0; i + 1 < s; i++)
        begin
            c = 0;
            for (int j = 0; j < set_len; j++)
                if (in_slab(slab_proj(j), lo, s, t, i, span)) c++;
            if (c > best_n)
            begin
                best_n = c;
                best = i;
            end
        end
        first_k = picks_due.size();
        for (int j = 0; j < set_len; j++)
        begin
            if (in_slab(slab_proj(j), lo, s, t, best, span))
            begin
                r = '{set_pts[j][0], set_pts[j][1], set_pts[j][2], 6'(j), 5'(best),
                      1'b0, set_ovf, 1'b0};
                picks_due.insert(picks_due.size(), r);
            end
        end
        if (picks_due.size() == first_k)
        begin
            r = '{16'sd0, 16'sd0, 16'sd0, 6'd0, 5'(best), 1'b1, set_ovf, 1'b1};
            picks_due.insert(picks_due.size(), r);
        end
        else
            picks_due[$].last = 1'b1;
        set_len = 0;
        set_ovf = 1'b0;
    endtask

    // push one point through the start handshake; start stays high on return
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic lst);
        start <= 1'b1;
        point_x <= x; point_y <= y; point_z <= z; last_point <= lst;
        while (busy) @(negedge clk);
        @(posedge clk);
        if (set_len < CAPACITY)
        begin
            set_pts[set_len][0] = x;
            set_pts[set_len][1] = y;
            set_pts[set_len][2] = z;
            set_len++;
        end
        else
            set_ovf = 1'b1;
        if (lst) close_set();
        n_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (picks_due.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // one register write; wr_en stays high on return
    task automatic write_reg(logic [dss_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
        @(negedge clk);
        case (idx)
            dss_pkg::REG_NORMAL_X:   nx = val;
            dss_pkg::REG_NORMAL_Y:   ny = val;
            dss_pkg::REG_NORMAL_Z:   nz = val;
            dss_pkg::REG_SLAB_COUNT: slabs = val[5:0];
            dss_pkg::REG_THRESH_DIV: tdiv = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] s, logic [15:0] t);
        write_reg(dss_pkg::REG_NORMAL_X, x);
        write_reg(dss_pkg::REG_NORMAL_Y, y);
        write_reg(dss_pkg::REG_NORMAL_Z, z);
        write_reg(dss_pkg::REG_SLAB_COUNT, s);
        write_reg(dss_pkg::REG_THRESH_DIV, t);
        wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 20)) - 16'sd10;
            default: return 16'($urandom_range(0, 4)) * 16'sd1000;
        endcase
    endfunction

    // random set: a few clustered layers, sometimes wide noise or over capacity
    task automatic send_random_set(int n, int mode);
        int gap;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       k == n - 1);
        end
        start <= 1'b0;
    endtask

    // result checking against the oldest pending pick
    always @(posedge clk)
    begin
        slab_pick_t e;
        if (rst_n && result_valid)
        begin
            idle_cycles <= 0;
            if (picks_due.size() == 0)
            begin
                $display("%0t: expected no result, actual idx=%0d", $time, out_index);
                errors++;
            end
            else
            begin
                e = picks_due.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
                    out_index !== e.idx || winning_plane !== e.plane ||
                    none_found !== e.none || overflowed !== e.ovf ||
                    last_result !== e.last)
                begin
                    $display("%0t: expected %0d %0d %0d i%0d p%0d n%0b o%0b l%0b",
                             $time, e.x, e.y, e.z, e.idx, e.plane, e.none, e.ovf,
                             e.last);
                    $display("%0t: actual   %0d %0d %0d i%0d p%0d n%0b o%0b l%0b",
                             $time, out_x, out_y, out_z, out_index, winning_plane,
                             none_found, overflowed, last_result);
                    errors++;
                end
            end
        end
        else if (rst_n && start && !busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    point_row_t dir_rows [$];
    int         dir_first;

    initial
    begin
        set_len = 0;
        set_ovf = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: single point, zero span, extremes, duplicates
        dir_rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0},
            '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, 1'b0, 1'b0},
            '{16'sd5, 16'sd5, 16'sd0, 1'b0, 1'b0, 1'b0},
            '{16'sd5, 16'sd5, 16'sd400, 1'b0, 1'b0, 1'b0},
            '{16'sd5, 16'sd5, 16'sd400, 1'b0, 1'b0, 1'b0},
            '{16'sd5, 16'sd5, 16'sd800, 1'b1, 1'b0, 1'b0},
            '{16'sh5555, -16'sh2AAB, 16'sd100, 1'b0, 1'b0, 1'b0},
            '{-16'sh5556, 16'sh2AAA, 16'sd100, 1'b1, 1'b1, 1'b1}
        };
        foreach (dir_rows[k])
        begin
            dir_first = picks_due.size();
            send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].last);
            // an all-coplanar set gives the typed-in empty result
            if (dir_rows[k].fixed && (picks_due.size() != dir_first + 1 ||
                picks_due[dir_first].none !== dir_rows[k].none ||
                picks_due[dir_first].plane != 0))
            begin
                $display("%0t: expected empty result on row %0d", $time, k);
                errors++;
            end
        end
        start <= 1'b0;
        wait_idle();

        // out-of-range slab count and divider, then extremes
        set_normal(16'h4000, 16'h0000, 16'h0000, 16'd0, 16'd0);
        send_random_set(12, 2);
        wait_idle();
        set_normal(16'hC000, 16'h4000, 16'h4000, 16'd63, 16'd127);
        send_random_set(12, 2);
        wait_idle();
        set_normal(16'h2D41, 16'hD2BF, 16'h0000, 16'd32, 16'd64);
        send_random_set(20, 1);
        wait_idle();
        set_normal(16'hFFFF, 16'h8000, 16'h7FFF, 16'd2, 16'd1);
        send_random_set(10, 0);
        wait_idle();
        // over capacity, the last three points dropped
        set_normal(16'h0000, 16'h0000, 16'h4000, 16'd8, 16'd2);
        send_random_set(CAPACITY + 3, 2);
        wait_idle();

        // random phases, sometimes with fresh settings between them
        while (n_sent < 500)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                set_normal(16'($urandom_range(0, 32768)) - 16'd16384,
                           16'($urandom_range(0, 32768)) - 16'd16384,
                           16'($urandom_range(0, 32768)) - 16'd16384,
                           16'($urandom_range(0, 63)), 16'($urandom_range(0, 127)));
            end
            send_random_set($urandom_range(1, 20), $urandom_range(0, 3) == 0 ? 0 :
                            $urandom_range(1, 2));
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
            wait_idle();
        end

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dss_near.sv
rtl/densest_slab_select.sv
sim/tb_top.sv
